// ===== design/tpch_pkg.sv =====
package tpch_pkg;

  localparam int unsigned KINDS       = 6;
  localparam int unsigned KIND_DEPTH  = 4096;
  localparam int unsigned KIND_AW     = 12;
  localparam int unsigned STORE_DEPTH = 24576;
  localparam int unsigned IN_W        = 168;
  localparam int unsigned OUT_W       = 48;

  localparam logic [4:0] MU_INCL = 5'd12;
  localparam logic [4:0] EL_INCL = 5'd24;

  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_TAG_REJ  = 3'd1,
    ST_ETA_REJ  = 3'd2,
    ST_PT_LOW   = 3'd3,
    ST_READ     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SO_ID_FAIL  = 2'd0,
    SO_IP_FAIL  = 2'd1,
    SO_ISO_FAIL = 2'd2,
    SO_PASS     = 2'd3
  } stage_e;

  typedef enum logic [1:0] {
    REG_MUON_MODE = 2'd0,
    REG_ISO_LIMIT = 2'd1,
    REG_D0_LIMIT  = 2'd2,
    REG_DZ_LIMIT  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_PASS2,
    BK_RESP
  } bk_state_e;

  // classified job handed from front to back
  typedef struct packed {
    logic        is_read;
    logic        do_count;
    status_e     status;
    logic [4:0]  region;
    logic [4:0]  incl;
    stage_e      stage;
    logic [6:0]  bin;
    logic [2:0]  rd_kind;
    logic [11:0] rd_addr;
  } job_t;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    logic [15:0] r;
    r = v[15] ? (~v + 16'd1) : v;
    return r;
  endfunction

endpackage

// ===== design/tag_probe_cutflow_histogrammer_top.sv =====
// Tag-probe cut-flow histogrammer.
// s_axis_*: one word per command (event or counter read). m_axis_*: one
// result word per command, in order. cfg_*: register writes (index, data);
// cfg_ready_o is low during the clearing pass, write only with no word in flight.
// The front classifies a word in its accept cycle (tag cuts, pt/eta region,
// mass bin) and pushes a job into a two-entry queue. The back owns six
// counter memories, one per histogram kind, 4096 counters each; an event
// does a read-modify-write for the probe region, then one for the inclusive
// region. An event steps the back through BK_READ, BK_PASS2 and BK_RESP,
// a read or reject through BK_READ and BK_RESP (result register must drain
// before the next job).
// After reset the back clears all 4096 counter rows, one row per cycle;
// input words queue in front (two) and then tready drops.
// A stalled receiver holds the result register; the back then waits and the
// queue fills, after which s_axis_tready goes low.
module tag_probe_cutflow_histogrammer_top
  import tpch_pkg::*;
#(
  parameter int unsigned MASS_BINS   = 120,
  parameter int unsigned MAX_REGIONS = 25,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command, tag_iso, tag_d0, tag_dz, probe_pt, probe_eta, probe_iso,
  // probe_d0, probe_dz, id_flags, pair_mass, read_address, zero pad
  input  logic [IN_W-1:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, region, stage_outcome, count_value, zero pad
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  logic        muon_mode_q;
  logic [15:0] iso_limit_q;
  logic [14:0] d0_limit_q, dz_limit_q;
  logic        job_valid, job_ready, busy;
  job_t        job;

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      muon_mode_q <= 1'b0;
      iso_limit_q <= 16'd90;
      d0_limit_q  <= 15'd100;
      dz_limit_q  <= 15'd1000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_MUON_MODE: muon_mode_q <= cfg_data_i[0];
        REG_ISO_LIMIT: iso_limit_q <= cfg_data_i;
        REG_D0_LIMIT:  d0_limit_q  <= cfg_data_i[14:0];
        REG_DZ_LIMIT:  dz_limit_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  tpch_front #(
    .MASS_BINS(MASS_BINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .data_i      (s_axis_tdata),
    .muon_mode_i (muon_mode_q),
    .iso_limit_i (iso_limit_q),
    .d0_limit_i  (d0_limit_q),
    .dz_limit_i  (dz_limit_q),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  tpch_back #(
    .MAX_REGIONS(MAX_REGIONS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .busy_o      (busy),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule

// ===== design/tpch_ram.sv =====
module tpch_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/tpch_front.sv =====
module tpch_front
  import tpch_pkg::*;
#(
  parameter int unsigned MASS_BINS = 120
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [IN_W-1:0] data_i,
  input  logic           muon_mode_i,
  input  logic [15:0]    iso_limit_i,
  input  logic [14:0]    d0_limit_i,
  input  logic [14:0]    dz_limit_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output job_t           job_o
);

  // two-entry queue
  job_t       q_mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  logic        command;
  logic [15:0] tag_iso, tag_d0, tag_dz, probe_eta, probe_iso, probe_d0, probe_dz;
  logic [15:0] pair_mass, aeta;
  logic [19:0] probe_pt;
  logic [1:0]  id_flags;
  logic [14:0] read_address;
  logic        tag_ok, pip_ok, pt_low, eta_rej;
  logic [2:0]  col;
  logic [4:0]  region;
  logic [6:0]  bin;
  logic [9:0]  quo;
  job_t        job;

  assign command      = data_i[0];
  assign tag_iso      = data_i[16:1];
  assign tag_d0       = data_i[32:17];
  assign tag_dz       = data_i[48:33];
  assign probe_pt     = data_i[68:49];
  assign probe_eta    = data_i[84:69];
  assign probe_iso    = data_i[100:85];
  assign probe_d0     = data_i[116:101];
  assign probe_dz     = data_i[132:117];
  assign id_flags     = data_i[134:133];
  assign pair_mass    = data_i[150:135];
  assign read_address = data_i[165:151];

  always_comb begin
    aeta    = mag16(probe_eta);
    tag_ok  = (tag_iso <= iso_limit_i) && (mag16(tag_d0) <= {1'b0, d0_limit_i})
              && (mag16(tag_dz) <= {1'b0, dz_limit_i}) && id_flags[0];
    pip_ok  = (mag16(probe_d0) <= {1'b0, d0_limit_i})
              && (mag16(probe_dz) <= {1'b0, dz_limit_i});
    if (muon_mode_i) begin
      pt_low  = probe_pt <= 20'd1000;
      eta_rej = 1'b0;
      if      (probe_pt <= 20'd1500) col = 3'd0;
      else if (probe_pt <= 20'd2000) col = 3'd1;
      else if (probe_pt <= 20'd3000) col = 3'd2;
      else if (probe_pt <= 20'd4000) col = 3'd3;
      else if (probe_pt <= 20'd5000) col = 3'd4;
      else                           col = 3'd5;
      region = {2'b00, col} + ((aeta <= 16'd12000) ? 5'd0 : 5'd6);
    end else begin
      pt_low  = probe_pt < 20'd1000;
      eta_rej = (aeta >= 16'd24000) || (aeta >= 16'd14442 && aeta < 16'd15660);
      if      (probe_pt < 20'd1500) col = 3'd0;
      else if (probe_pt < 20'd2000) col = 3'd1;
      else if (probe_pt < 20'd3000) col = 3'd2;
      else if (probe_pt < 20'd4000) col = 3'd3;
      else if (probe_pt < 20'd5000) col = 3'd4;
      else                          col = 3'd5;
      if      (aeta >= 16'd20000) region = {2'b00, col} + 5'd18;
      else if (aeta >= 16'd15660) region = {2'b00, col} + 5'd12;
      else if (aeta >= 16'd8000)  region = {2'b00, col} + 5'd6;
      else                        region = {2'b00, col};
    end
    // mass / 100 by reciprocal: floor(m*5243 >> 19) is exact below the overflow clamp
    quo = 10'(({16'd0, pair_mass} * 32'd5243) >> 19);
    bin = (quo > 10'(MASS_BINS)) ? 7'(MASS_BINS) : quo[6:0];

    job          = '0;
    job.region   = region;
    job.incl     = muon_mode_i ? MU_INCL : EL_INCL;
    job.bin      = bin;
    job.rd_kind  = read_address[14:12];
    job.rd_addr  = read_address[11:0];
    if (command) begin
      job.is_read = 1'b1;
      job.status  = ST_READ;
      job.region  = '0;
    end else if (!tag_ok) begin
      job.status = ST_TAG_REJ;
    end else if (pt_low) begin
      job.status = ST_PT_LOW;
    end else if (eta_rej) begin
      job.status = ST_ETA_REJ;
    end else begin
      job.status   = ST_COUNTED;
      job.do_count = 1'b1;
      if (!id_flags[1])                job.stage = SO_ID_FAIL;
      else if (!pip_ok)                job.stage = SO_IP_FAIL;
      else if (probe_iso > iso_limit_i) job.stage = SO_ISO_FAIL;
      else                             job.stage = SO_PASS;
    end
    if (!job.do_count) begin
      job.region = '0;
    end
  end

  assign ready_o     = cnt_q != 2'd2;
  assign job_valid_o = cnt_q != 2'd0;
  assign job_o       = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      q_mem_q[wp_q] <= job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (valid_i && ready_o) wp_q <= ~wp_q;
      if (job_valid_o && job_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(valid_i && ready_o) - 2'(job_valid_o && job_ready_i);
    end
  end

endmodule

// ===== design/tpch_back.sv =====
module tpch_back
  import tpch_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = 25,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  job_t            job_i,
  output logic            busy_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [OUT_W-1:0] m_data_o
);

  localparam logic [COUNT_WIDTH-1:0] MAXC = '1;

  // clearing pass over the 4096 rows after reset, all six memories at once
  logic [KIND_AW:0]  clr_q;
  logic              clearing;
  bk_state_e         st_q, st_d;
  job_t              job_q;
  logic              pass_q;
  logic              out_v_q;
  logic [OUT_W-1:0]  out_q;

  logic [KIND_AW-1:0]     raddr, waddr;
  logic [KINDS-1:0]       we;
  logic [COUNT_WIDTH-1:0] rdata [KINDS];
  logic [COUNT_WIDTH-1:0] wdata [KINDS];
  logic [KINDS-1:0]       hit;
  logic [4:0]             cur_region;
  logic                   reg_ok;
  logic [COUNT_WIDTH-1:0] rd_val;

  assign clearing = !clr_q[KIND_AW];
  assign busy_o   = clearing;

  // pass 0 handles the probe region, pass 1 the inclusive one
  assign cur_region = pass_q ? job_q.incl : job_q.region;
  assign reg_ok     = 32'(cur_region) < MAX_REGIONS;

  always_comb begin
    hit = '0;
    if (job_q.do_count) begin
      case (job_q.stage)
        SO_ID_FAIL:  hit = 6'b000010;
        SO_IP_FAIL:  hit = 6'b001001;
        SO_ISO_FAIL: hit = 6'b100101;
        default:     hit = 6'b010101;
      endcase
    end
  end

  always_comb begin
    if (st_q == BK_IDLE) begin
      raddr = job_i.is_read ? job_i.rd_addr
                            : {job_i.region, job_i.bin};
    end else begin
      raddr = {job_q.incl, job_q.bin};
    end
    waddr = clearing ? clr_q[KIND_AW-1:0] : {cur_region, job_q.bin};
    for (int k = 0; k < KINDS; k++) begin
      if (clearing) begin
        we[k]    = 1'b1;
        wdata[k] = '0;
      end else begin
        we[k]    = (st_q == BK_READ || st_q == BK_PASS2) && hit[k] && reg_ok;
        wdata[k] = (rdata[k] == MAXC) ? rdata[k] : rdata[k] + 1'b1;
      end
    end
  end

  for (genvar k = 0; k < KINDS; k++) begin : g_mem
    tpch_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(KIND_DEPTH)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[k]),
      .waddr_i(waddr),
      .wdata_i(wdata[k]),
      .raddr_i(raddr),
      .rdata_o(rdata[k])
    );
  end

  always_comb begin
    rd_val = '0;
    if (job_q.rd_kind < 3'(KINDS)) rd_val = rdata[job_q.rd_kind];
  end

  assign job_ready_o = (st_q == BK_IDLE) && !clearing && !out_v_q;
  assign m_valid_o   = out_v_q;
  assign m_data_o    = out_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE:  if (job_valid_i && job_ready_o) st_d = BK_READ;
      BK_READ:  st_d = job_q.do_count ? BK_PASS2 : BK_RESP;
      BK_PASS2: st_d = BK_RESP;
      BK_RESP:  st_d = BK_IDLE;
      default:  st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE && job_valid_i && job_ready_o) job_q <= job_i;
    if (st_q == BK_READ || st_q == BK_PASS2) begin
      out_q <= {6'd0, (job_q.is_read ? 32'(rd_val) : 32'd0), job_q.stage,
                job_q.region, job_q.status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_IDLE;
      pass_q  <= 1'b0;
      out_v_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      st_q <= st_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      pass_q <= (st_q == BK_READ);
      if (st_q == BK_RESP) out_v_q <= 1'b1;
      else if (m_ready_i) out_v_q <= 1'b0;
    end
  end

endmodule

// ===== design/tpch_checker.sv =====
module tpch_checker
  import tpch_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
    else $error("bad status");

  a_noncount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[9:3] == 7'd0)
    else $error("region or stage set on uncounted word");

  a_readonly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'd4 |-> m_axis_tdata[41:10] == 32'd0)
    else $error("count on non-read word");

endmodule

bind tag_probe_cutflow_histogrammer_top tpch_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
